// ===== rtl/rck_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rck_pkg: radio channel keeper shared definitions
// Types, register indexes, reset values and channel-order helpers.
// ----------------------------------------------------------------------------
package rck_pkg;

  localparam int unsigned NUM_SCAN_CHANNELS_DEF = 13;
  localparam int unsigned CHAN_W                = 4;
  localparam int unsigned PHASE_W               = 20;
  localparam int unsigned SILENCE_W             = 21;
  localparam int unsigned CFG_IDX_W             = 3;
  localparam int unsigned CFG_DATA_W            = 20;

  localparam logic [CHAN_W-1:0]    CHAN_FIRST  = 4'd1;
  localparam logic [CHAN_W-1:0]    CHAN_LAST   = 4'd13;
  localparam logic [PHASE_W-1:0]   PHASE_MAX   = '1;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX = '1;

  localparam logic [15:0] DWELL_RST       = 16'd200;
  localparam logic [15:0] MONITOR_RST     = 16'd1000;
  localparam logic [19:0] LOST_RST        = 20'd5000;
  localparam logic [19:0] BACKOFF_MIN_RST = 20'd1000;
  localparam logic [19:0] BACKOFF_MAX_RST = 20'd30000;
  localparam logic [3:0]  DEF_CHAN_RST    = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DWELL       = 3'd0,
    REG_MONITOR     = 3'd1,
    REG_LOST        = 3'd2,
    REG_BACKOFF_MIN = 3'd3,
    REG_BACKOFF_MAX = 3'd4,
    REG_DEF_CHAN    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_LOCKED  = 2'd1,
    MODE_BACKOFF = 2'd2
  } mode_t;

  typedef struct packed {
    logic [15:0] dwell_ms;
    logic [15:0] monitor_interval_ms;
    logic [19:0] lost_timeout_ms;
    logic [19:0] backoff_min_ms;
    logic [19:0] backoff_max_ms;
    logic [3:0]  default_channel;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              locked;
    logic              retuned;
  } res_t;

  function automatic logic [CHAN_W-1:0] chan_order(input logic [3:0] idx);
    logic [CHAN_W-1:0] ch;
    case (idx)
      4'd0:    ch = 4'd1;
      4'd1:    ch = 4'd6;
      4'd2:    ch = 4'd11;
      4'd3:    ch = 4'd2;
      4'd4:    ch = 4'd3;
      4'd5:    ch = 4'd4;
      4'd6:    ch = 4'd5;
      4'd7:    ch = 4'd7;
      4'd8:    ch = 4'd8;
      4'd9:    ch = 4'd9;
      4'd10:   ch = 4'd10;
      4'd11:   ch = 4'd12;
      default: ch = CHAN_LAST;
    endcase
    return ch;
  endfunction

  function automatic logic [CHAN_W-1:0] park_channel(input logic [3:0] dc);
    logic [CHAN_W-1:0] ch;
    if (dc == 4'd0) begin
      ch = CHAN_FIRST;
    end else if (dc > CHAN_LAST) begin
      ch = CHAN_LAST;
    end else begin
      ch = dc;
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/radio_channel_keeper_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radio_channel_keeper_unit: hub channel scan, lock and backoff keeper
// Usage:
//   Input channel: one transfer per millisecond tick, in_hub_heard set when
//   a hub packet arrived during that tick.
//   Result channel: one transfer per tick with the channel tuned after the
//   tick, the locked flag and a retune flag.
//   Config channel: cfg_index selects the setting (0 dwell, 1 monitor
//   interval, 2 lost timeout, 3 backoff min, 4 backoff max, 5 default
//   channel); cfg_ready is always high. Write only while no tick is pending.
//   Result: registered into the output entry, or the skid entry when held.
//   Throughput: one tick per cycle while in_stall is low.
//   Stall: a two-entry output buffer absorbs one extra result; in_stall rises
//   once both entries are full and drops when the receiver takes one.
//   Reset: synchronous, active low; scanning from the first channel of the
//   order, settings back to their defaults, output buffer empty.
// ----------------------------------------------------------------------------
module radio_channel_keeper_unit #(
  parameter int unsigned NUM_SCAN_CHANNELS = rck_pkg::NUM_SCAN_CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_hub_heard,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rck_pkg::CHAN_W-1:0]          out_channel,
  output logic                                out_locked,
  output logic                                out_retuned,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rck_pkg::CFG_DATA_W-1:0] cfg_data
);

  rck_pkg::cfg_t cfg;
  rck_pkg::res_t step_res;
  rck_pkg::res_t out_res;
  logic          tick_fire;

  assign tick_fire   = in_valid & ~in_stall;
  assign out_channel = out_res.channel;
  assign out_locked  = out_res.locked;
  assign out_retuned = out_res.retuned;

  rck_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rck_step #(
    .NUM_SCAN_CHANNELS (NUM_SCAN_CHANNELS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_fire (tick_fire),
    .hub_heard (in_hub_heard),
    .cfg       (cfg),
    .res       (step_res)
  );

  rck_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_res    (step_res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

// ===== rtl/rck_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rck_cfg_regs: configuration register bank
// Holds the six keeper settings; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module rck_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rck_pkg::CFG_DATA_W-1:0] cfg_data,
  output rck_pkg::cfg_t                       cfg
);

  rck_pkg::cfg_t cfg_r;
  rck_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (rck_pkg::reg_idx_t'(cfg_index))
        rck_pkg::REG_DWELL:       cfg_nxt.dwell_ms            = cfg_data[15:0];
        rck_pkg::REG_MONITOR:     cfg_nxt.monitor_interval_ms = cfg_data[15:0];
        rck_pkg::REG_LOST:        cfg_nxt.lost_timeout_ms     = cfg_data;
        rck_pkg::REG_BACKOFF_MIN: cfg_nxt.backoff_min_ms      = cfg_data;
        rck_pkg::REG_BACKOFF_MAX: cfg_nxt.backoff_max_ms      = cfg_data;
        rck_pkg::REG_DEF_CHAN:    cfg_nxt.default_channel     = cfg_data[3:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell_ms            <= rck_pkg::DWELL_RST;
      cfg_r.monitor_interval_ms <= rck_pkg::MONITOR_RST;
      cfg_r.lost_timeout_ms     <= rck_pkg::LOST_RST;
      cfg_r.backoff_min_ms      <= rck_pkg::BACKOFF_MIN_RST;
      cfg_r.backoff_max_ms      <= rck_pkg::BACKOFF_MAX_RST;
      cfg_r.default_channel     <= rck_pkg::DEF_CHAN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rck_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rck_step: keeper state and per-tick update
// Counters and mode register, advanced once per accepted tick.
// ----------------------------------------------------------------------------
module rck_step #(
  parameter int unsigned NUM_SCAN_CHANNELS = rck_pkg::NUM_SCAN_CHANNELS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         tick_fire,
  input  wire logic         hub_heard,
  input  wire rck_pkg::cfg_t cfg,
  output rck_pkg::res_t     res
);

  localparam int unsigned LEN_CLAMP = (NUM_SCAN_CHANNELS < 1) ? 1 :
                                      ((NUM_SCAN_CHANNELS > 16) ? 16 : NUM_SCAN_CHANNELS);
  localparam logic [4:0]  ORDER_LEN = 5'(LEN_CLAMP);

  rck_pkg::mode_t                      mode_r, mode_nxt;
  logic [3:0]                          idx_r, idx_nxt;
  logic [rck_pkg::CHAN_W-1:0]          chan_r, chan_nxt;
  logic [rck_pkg::PHASE_W-1:0]         phase_r, phase_nxt;
  logic                                hst_r, hst_nxt;
  logic                                ever_r, ever_nxt;
  logic [rck_pkg::SILENCE_W-1:0]       sil_r, sil_nxt;
  logic [19:0]                         bo_r, bo_nxt;

  always_comb begin
    mode_nxt  = mode_r;
    idx_nxt   = idx_r;
    chan_nxt  = chan_r;
    bo_nxt    = bo_r;
    hst_nxt   = hst_r | hub_heard;
    ever_nxt  = ever_r | hub_heard;
    if (hub_heard) begin
      sil_nxt = '0;
    end else if (sil_r != rck_pkg::SILENCE_MAX) begin
      sil_nxt = sil_r + 1'b1;
    end else begin
      sil_nxt = sil_r;
    end
    phase_nxt = (phase_r != rck_pkg::PHASE_MAX) ? phase_r + 1'b1 : phase_r;

    case (mode_r)
      rck_pkg::MODE_LOCKED: begin
        if (phase_nxt >= {4'd0, cfg.monitor_interval_ms}) begin
          phase_nxt = '0;
          if (sil_nxt > {1'b0, cfg.lost_timeout_ms}) begin
            mode_nxt = rck_pkg::MODE_SCAN;
            idx_nxt  = '0;
            chan_nxt = rck_pkg::chan_order(4'd0);
            hst_nxt  = 1'b0;
          end
        end
      end
      rck_pkg::MODE_BACKOFF: begin
        if (phase_nxt >= bo_r) begin
          if (bo_r >= (cfg.backoff_max_ms >> 1)) begin
            bo_nxt = cfg.backoff_max_ms;
          end else begin
            bo_nxt = {bo_r[18:0], 1'b0};
          end
          mode_nxt  = rck_pkg::MODE_SCAN;
          idx_nxt   = '0;
          chan_nxt  = rck_pkg::chan_order(4'd0);
          phase_nxt = '0;
          hst_nxt   = 1'b0;
        end
      end
      default: begin
        if (phase_nxt >= {4'd0, cfg.dwell_ms}) begin
          phase_nxt = '0;
          if (hst_nxt && ever_nxt) begin
            mode_nxt = rck_pkg::MODE_LOCKED;
            bo_nxt   = cfg.backoff_min_ms;
          end else if (({1'b0, idx_r} + 5'd1) < ORDER_LEN) begin
            idx_nxt  = idx_r + 4'd1;
            chan_nxt = rck_pkg::chan_order(idx_r + 4'd1);
            hst_nxt  = 1'b0;
          end else begin
            mode_nxt = rck_pkg::MODE_BACKOFF;
            chan_nxt = rck_pkg::park_channel(cfg.default_channel);
            hst_nxt  = 1'b0;
          end
        end
      end
    endcase
  end

  always_comb begin
    res.channel = chan_nxt;
    res.locked  = (mode_nxt == rck_pkg::MODE_LOCKED);
    res.retuned = (chan_nxt != chan_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rck_pkg::MODE_SCAN;
      idx_r   <= '0;
      chan_r  <= rck_pkg::chan_order(4'd0);
      phase_r <= '0;
      hst_r   <= 1'b0;
      ever_r  <= 1'b0;
      sil_r   <= '0;
      bo_r    <= rck_pkg::BACKOFF_MIN_RST;
    end else if (tick_fire) begin
      mode_r  <= mode_nxt;
      idx_r   <= idx_nxt;
      chan_r  <= chan_nxt;
      phase_r <= phase_nxt;
      hst_r   <= hst_nxt;
      ever_r  <= ever_nxt;
      sil_r   <= sil_nxt;
      bo_r    <= bo_nxt;
    end
  end

`ifndef SYNTHESIS
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r != 4'd0 && chan_r <= rck_pkg::CHAN_LAST)
    else $error("tuned channel out of range");
  a_lock_needs_hub: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == rck_pkg::MODE_LOCKED |-> ever_r)
    else $error("locked without hub ever heard");
  a_heard_clears_silence: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && hub_heard |=> sil_r == '0)
    else $error("silence count not cleared by hub packet");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> {1'b0, idx_r} < ORDER_LEN)
    else $error("sweep index past order length");
`endif

endmodule
`default_nettype wire

// ===== rtl/rck_out_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rck_out_buf: result register with skid stage
// Two-entry output buffer; upstream stall is registered.
// ----------------------------------------------------------------------------
module rck_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rck_pkg::res_t in_res,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rck_pkg::res_t      out_res
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  rck_pkg::res_t out_res_r, out_res_nxt;
  rck_pkg::res_t skid_res_r, skid_res_nxt;
  logic          accept;
  logic          take;

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign accept    = in_valid & ~skid_valid_r;
  assign take      = out_valid_r & ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (take) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_res_nxt   = in_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = in_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule
`default_nettype wire
